[rtl/core/strc_pkg.sv]
package strc_pkg;

    localparam int CFG_W = 11;
    localparam int POS_W = 10;
    localparam int CNT_W = 16;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    localparam logic KIND_UPDATE = 1'b0;
    localparam logic KIND_QUERY  = 1'b1;

endpackage

[rtl/core/strc_ram.sv]
module strc_ram #(
    parameter int DEPTH = 2048
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [$clog2(DEPTH)-1:0]   i_waddr,
    input  logic [strc_pkg::CNT_W-1:0] i_wdata,
    input  logic [$clog2(DEPTH)-1:0]   i_raddr,
    output logic [strc_pkg::CNT_W-1:0] o_rdata
);

    logic [strc_pkg::CNT_W-1:0] r_mem [DEPTH];
    logic [strc_pkg::CNT_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/segment_tree_range_count.sv]
// Channel   Direction  Handshake                   Payload
// input     in         i_in_valid / o_in_ready     i_kind, i_position, i_range_low, i_range_high
// output    out        o_out_valid / i_out_ready   o_count
// config    in         i_cfg_we (no wait)          i_cfg_wdata
//
// After acceptance, an update visits each tree level with a read state and then a saturating
// write state; a query walks the shared descent and then each of the two boundary walks, level
// by level, then drains the last addition and hands the result to the output register, all
// through the one node memory and the one saturating adder. After reset and after every
// configuration write the node memory is cleared, one entry a cycle, over all 2 * LEAVES
// entries with input ready low.
// A finished result waits in the output register while the next transaction is taken.
module segment_tree_range_count #(
    parameter int LEAVES = 1024
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic                       i_kind,
    input  logic [strc_pkg::POS_W-1:0] i_position,
    input  logic [strc_pkg::POS_W-1:0] i_range_low,
    input  logic [strc_pkg::POS_W-1:0] i_range_high,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [strc_pkg::CNT_W-1:0] o_count,
    input  logic                       i_cfg_we,
    input  logic [strc_pkg::CFG_W-1:0] i_cfg_wdata
);

    localparam int SLOTS = 2 * LEAVES;
    localparam int AW    = $clog2(SLOTS);
    localparam int LW    = $clog2(LEAVES + 1);
    localparam int CW    = (LW > strc_pkg::CFG_W) ? LW : strc_pkg::CFG_W;

    localparam logic [AW:0]   SLOTS_X  = (AW + 1)'(SLOTS);
    localparam logic [AW-1:0] LAST_SLOT = AW'(SLOTS - 1);
    localparam logic [AW-1:0] ROOT     = AW'(1);
    localparam logic [CW-1:0] LEAVES_X = CW'(LEAVES);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_UPD_RD,
        S_UPD_WR,
        S_Q_DESC,
        S_Q_LEFT,
        S_Q_RIGHT,
        S_Q_DRAIN,
        S_DONE
    } t_state;

    t_state                     r_state, n_state;
    logic [CW-1:0]              r_last, n_last;
    logic [AW-1:0]              r_clr, n_clr;
    logic [AW-1:0]              r_node, n_node;
    logic [CW-1:0]              r_lo, n_lo;
    logic [CW-1:0]              r_hi, n_hi;
    logic [AW-1:0]              r_rnode, n_rnode;
    logic [CW-1:0]              r_rlo, n_rlo;
    logic [CW-1:0]              r_rhi, n_rhi;
    logic [CW-1:0]              r_qa, n_qa;
    logic [CW-1:0]              r_qb, n_qb;
    logic [CW-1:0]              r_pos, n_pos;
    logic [strc_pkg::CNT_W-1:0] r_acc, n_acc;
    logic                       r_pend, n_pend;
    logic                       r_out_valid, n_out_valid;
    logic [strc_pkg::CNT_W-1:0] r_count, n_count;

    logic                       ram_we;
    logic [AW-1:0]              ram_waddr;
    logic [strc_pkg::CNT_W-1:0] ram_wdata;
    logic [AW-1:0]              ram_raddr;
    logic [strc_pkg::CNT_W-1:0] ram_rdata;

    logic [CW:0]                mid_sum;
    logic [CW-1:0]              mid;
    logic [CW-1:0]              mid_p1;
    logic [AW-1:0]              child_l;
    logic [AW-1:0]              child_r;
    logic                       node_in;
    logic                       child_in;
    logic [strc_pkg::CNT_W-1:0] add_a;
    logic [strc_pkg::CNT_W:0]   add_sum;
    logic [strc_pkg::CNT_W-1:0] add_sat;
    logic [CW-1:0]              cfg_x;
    logic [CW-1:0]              cfg_used;
    logic [CW-1:0]              pos_x;
    logic [CW-1:0]              qlo_x;
    logic [CW-1:0]              qhi_x;
    logic                       out_free;

    strc_ram #(
        .DEPTH (SLOTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign mid_sum  = {1'b0, r_lo} + {1'b0, r_hi};
    assign mid      = mid_sum[CW:1];
    assign mid_p1   = mid + CW'(1);
    assign child_l  = {r_node[AW-2:0], 1'b0};
    assign child_r  = {r_node[AW-2:0], 1'b1};
    assign node_in  = ({1'b0, r_node} < SLOTS_X);
    assign child_in = ({1'b0, child_l} < SLOTS_X);

    // The one adder serves both the node increment and the query accumulation.
    assign add_a   = (r_state == S_UPD_WR) ? strc_pkg::CNT_W'(1) : r_acc;
    assign add_sum = {1'b0, add_a} + {1'b0, ram_rdata};
    assign add_sat = add_sum[strc_pkg::CNT_W] ? strc_pkg::CNT_MAX
                                               : add_sum[strc_pkg::CNT_W-1:0];

    assign cfg_x    = CW'(i_cfg_wdata);
    assign cfg_used = (cfg_x == '0) ? CW'(1) : ((cfg_x > LEAVES_X) ? LEAVES_X : cfg_x);
    assign pos_x    = CW'(i_position);
    assign qlo_x    = CW'(i_range_low);
    assign qhi_x    = CW'(i_range_high);
    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state     = r_state;
        n_last      = r_last;
        n_clr       = r_clr;
        n_node      = r_node;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_rnode     = r_rnode;
        n_rlo       = r_rlo;
        n_rhi       = r_rhi;
        n_qa        = r_qa;
        n_qb        = r_qb;
        n_pos       = r_pos;
        n_acc       = r_pend ? add_sat : r_acc;
        n_pend      = 1'b0;
        n_out_valid = r_out_valid && !i_out_ready;
        n_count     = r_count;
        ram_we      = 1'b0;
        ram_waddr   = r_node;
        ram_wdata   = add_sat;
        ram_raddr   = r_node;

        unique case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                ram_wdata = '0;
                if (r_clr == LAST_SLOT) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr = r_clr + AW'(1);
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_node = ROOT;
                    n_lo   = '0;
                    n_hi   = r_last;
                    n_pos  = pos_x;
                    n_acc  = '0;
                    if (i_kind == strc_pkg::KIND_UPDATE) begin
                        if (pos_x <= r_last) begin
                            n_state = S_UPD_RD;
                        end
                    end else begin
                        n_qa = qlo_x;
                        n_qb = (qhi_x > r_last) ? r_last : qhi_x;
                        if (qlo_x > ((qhi_x > r_last) ? r_last : qhi_x)) begin
                            n_state = S_DONE;
                        end else begin
                            n_state = S_Q_DESC;
                        end
                    end
                end
            end
            S_UPD_RD: begin
                n_state = node_in ? S_UPD_WR : S_IDLE;
            end
            S_UPD_WR: begin
                ram_we = 1'b1;
                if (r_lo == r_hi) begin
                    n_state = S_IDLE;
                end else if (r_pos <= mid) begin
                    n_node  = child_l;
                    n_hi    = mid;
                    n_state = S_UPD_RD;
                end else begin
                    n_node  = child_r;
                    n_lo    = mid_p1;
                    n_state = S_UPD_RD;
                end
            end
            S_Q_DESC: begin
                priority if (!node_in) begin
                    n_state = S_DONE;
                end else if (r_lo >= r_qa && r_hi <= r_qb) begin
                    n_pend  = 1'b1;
                    n_state = S_Q_DRAIN;
                end else if (r_qb <= mid) begin
                    n_node = child_l;
                    n_hi   = mid;
                end else if (r_qa > mid) begin
                    n_node = child_r;
                    n_lo   = mid_p1;
                end else begin
                    n_node  = child_l;
                    n_hi    = mid;
                    n_rnode = child_r;
                    n_rlo   = mid_p1;
                    n_rhi   = r_hi;
                    n_state = S_Q_LEFT;
                end
            end
            S_Q_LEFT: begin
                priority if (!node_in || r_lo >= r_qa) begin
                    n_pend  = node_in;
                    n_node  = r_rnode;
                    n_lo    = r_rlo;
                    n_hi    = r_rhi;
                    n_state = S_Q_RIGHT;
                end else if (r_qa <= mid) begin
                    ram_raddr = child_r;
                    n_pend    = child_in;
                    n_node    = child_l;
                    n_hi      = mid;
                end else begin
                    n_node = child_r;
                    n_lo   = mid_p1;
                end
            end
            S_Q_RIGHT: begin
                priority if (!node_in || r_hi <= r_qb) begin
                    n_pend  = node_in;
                    n_state = S_Q_DRAIN;
                end else if (r_qb > mid) begin
                    ram_raddr = child_l;
                    n_pend    = child_in;
                    n_node    = child_r;
                    n_lo      = mid_p1;
                end else begin
                    n_node = child_l;
                    n_hi   = mid;
                end
            end
            S_Q_DRAIN: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_count     = r_acc;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
                n_clr   = '0;
            end
        endcase

        // A new element count changes the tree shape, so every node is cleared.
        if (i_cfg_we) begin
            n_last  = cfg_used - CW'(1);
            n_clr   = '0;
            n_pend  = 1'b0;
            n_state = S_CLEAR;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_last      <= CW'(LEAVES - 1);
            r_clr       <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_last      <= n_last;
            r_clr       <= n_clr;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
        r_node  <= n_node;
        r_lo    <= n_lo;
        r_hi    <= n_hi;
        r_rnode <= n_rnode;
        r_rlo   <= n_rlo;
        r_rhi   <= n_rhi;
        r_qa    <= n_qa;
        r_qb    <= n_qb;
        r_pos   <= n_pos;
        r_acc   <= n_acc;
        r_count <= n_count;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_count     = r_count;

endmodule
